@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the blocked FP32 matrix multiply RTL
// Clocked implication checks, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds on that edge.
`define CHK_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define CHK_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/fgemm_pkg.sv @@
// ----------------------------------------------------------------------------
// fgemm_pkg
// Shared constants and the request/response types of the multiply-add unit.
// ----------------------------------------------------------------------------
package fgemm_pkg;

  // Block geometry: eight rows per block, eight depths per slice
  localparam int LANES       = 8;
  localparam int SLICE_WORDS = 64;

  // Item kinds
  localparam logic [1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  // IEEE single constants
  localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] INF_BITS    = 32'h7F80_0000;

  // Signed exponent width inside the multiply-add unit
  localparam int EXW = 12;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } fma_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] bits;
  } fma_rsp_t;

endpackage

@@ rtl/fgemm_ram.sv @@
// ----------------------------------------------------------------------------
// fgemm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fgemm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/fgemm_fma.sv @@
// ----------------------------------------------------------------------------
// fgemm_fma
// Multi-cycle FP32 fused multiply-add (a * b + c, one rounding, nearest even,
// subnormals kept) built around one multiplier and one shared normalizer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fgemm_fma (
  input  logic                clk,
  input  logic                rst_n,
  input  fgemm_pkg::fma_req_t req,
  output fgemm_pkg::fma_rsp_t rsp
);
  import fgemm_pkg::*;

  typedef enum logic [7:0] {
    F_IDLE  = 8'b0000_0001,
    F_MUL   = 8'b0000_0010,
    F_NRM   = 8'b0000_0100,
    F_SWAP  = 8'b0000_1000,
    F_ALIGN = 8'b0001_0000,
    F_ADD   = 8'b0010_0000,
    F_RND   = 8'b0100_0000,
    F_PACK  = 8'b1000_0000
  } fst_t;

  // Which operand the normalizer is working on
  localparam logic [1:0] NS_P = 2'd0;
  localparam logic [1:0] NS_C = 2'd1;
  localparam logic [1:0] NS_S = 2'd2;

  localparam logic signed [EXW-1:0] Q_MIN = EXW'(-149);

  function automatic logic is_nan(input logic [31:0] x);
    is_nan = (&x[30:23]) && (|x[22:0]);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    is_inf = (x[30:0] == INF_BITS[30:0]);
  endfunction

  function automatic logic is_zero(input logic [31:0] x);
    is_zero = (x[30:0] == 31'd0);
  endfunction

  function automatic logic [23:0] sig_of(input logic [31:0] x);
    sig_of = {|x[30:23], x[22:0]};
  endfunction

  function automatic logic signed [EXW-1:0] exp_of(input logic [31:0] x);
    if (x[30:23] == 8'd0) begin
      exp_of = EXW'(-149);
    end else begin
      exp_of = $signed({{(EXW-8){1'b0}}, x[30:23]}) - EXW'(150);
    end
  endfunction

  fst_t                    fst_r, fst_nxt;
  logic                    done_r;
  logic [31:0]             res_r;
  logic [23:0]             ma_r, mb_r, cm_r;
  logic signed [EXW-1:0]   pe_r, ce_r, pme_r, ebig_r, q_r;
  logic                    sp_r, sc_r, c_zero_r, sign_r, sub_r;
  logic [63:0]             nv_r, pm_r, big_r, small_r;
  logic signed [EXW-1:0]   ne_r;
  logic [2:0]              nstep_r;
  logic [1:0]              nsel_r;
  logic [EXW-1:0]          d_r;
  logic [24:0]             rr_r;

  // Special operands
  logic        spec_hit;
  logic [31:0] spec_val;
  logic        sp_c;

  always_comb begin
    sp_c     = req.a[31] ^ req.b[31];
    spec_hit = 1'b1;
    spec_val = 32'd0;
    if (is_nan(req.a)) begin
      spec_val = req.a | QUIET_BIT;
    end else if (is_nan(req.b)) begin
      spec_val = req.b | QUIET_BIT;
    end else if (is_nan(req.c)) begin
      spec_val = req.c | QUIET_BIT;
    end else if (is_inf(req.a) || is_inf(req.b)) begin
      if (is_zero(req.a) || is_zero(req.b)) begin
        spec_val = DEFAULT_NAN;
      end else if (is_inf(req.c) && (req.c[31] != sp_c)) begin
        spec_val = DEFAULT_NAN;
      end else begin
        spec_val = {sp_c, INF_BITS[30:0]};
      end
    end else if (is_inf(req.c)) begin
      spec_val = req.c;
    end else if (is_zero(req.a) || is_zero(req.b)) begin
      if (is_zero(req.c)) begin
        spec_val = (sp_c == req.c[31]) ? {sp_c, 31'd0} : 32'd0;
      end else begin
        spec_val = req.c;
      end
    end else begin
      spec_hit = 1'b0;
    end
  end

  // Shared normalizer: one binary-search step per cycle (32,16,...,1)
  logic [6:0]            n_amt;
  logic [63:0]           n_val;
  logic signed [EXW-1:0] n_exp;
  logic                  n_shift;

  always_comb begin
    n_amt   = 7'd32 >> nstep_r;
    n_shift = ((nv_r & ~({64{1'b1}} >> n_amt)) == 64'd0);
    n_val   = n_shift ? (nv_r << n_amt) : nv_r;
    n_exp   = n_shift ? (ne_r - $signed(EXW'(n_amt))) : ne_r;
  end

  // Operand order for the add
  logic [63:0]           c_al;
  logic signed [EXW-1:0] c_ale;
  logic                  p_big;

  always_comb begin
    c_al  = nv_r >> 2;
    c_ale = ne_r + EXW'(2);
    p_big = (pme_r > c_ale) || ((pme_r == c_ale) && (pm_r >= c_al));
  end

  // Alignment with sticky and the add itself
  logic [63:0] lost;
  logic [63:0] small_al;
  logic [63:0] sum_c;

  always_comb begin
    lost     = small_r & ~({64{1'b1}} << d_r[5:0]);
    small_al = (d_r >= EXW'(63)) ? 64'(|small_r)
                                 : ((small_r >> d_r[5:0]) | 64'(|lost));
    sum_c    = sub_r ? (big_r - small_r) : (big_r + small_r);
  end

  // Rounding shift to the final precision
  logic signed [EXW-1:0] q0, q_c, sh_c;
  logic [6:0]            shc;
  logic [127:0]          wide;
  logic                  g_bit, st_bit, inc;

  always_comb begin
    q0     = ne_r + EXW'(40);
    q_c    = (q0 < Q_MIN) ? Q_MIN : q0;
    sh_c   = q_c - ne_r;
    shc    = (sh_c > EXW'(65)) ? 7'd65 : sh_c[6:0];
    wide   = {nv_r, 64'd0} >> shc;
    g_bit  = wide[63];
    st_bit = |wide[62:0];
    inc    = g_bit && (st_bit || wide[64]);
  end

  // Pack
  logic [23:0]           rf;
  logic signed [EXW-1:0] qf, be;
  logic [31:0]           pack_c;

  always_comb begin
    rf = rr_r[24] ? rr_r[24:1] : rr_r[23:0];
    qf = rr_r[24] ? (q_r + EXW'(1)) : q_r;
    be = qf + EXW'(150);
    if (!rf[23]) begin
      pack_c = {sign_r, 8'd0, rf[22:0]};
    end else if (be >= EXW'(255)) begin
      pack_c = {sign_r, INF_BITS[30:0]};
    end else begin
      pack_c = {sign_r, be[7:0], rf[22:0]};
    end
  end

  // Sequencer
  always_comb begin
    fst_nxt = fst_r;
    case (fst_r)
      F_IDLE:  if (req.start && !spec_hit) fst_nxt = F_MUL;
      F_MUL:   fst_nxt = F_NRM;
      F_NRM: begin
        if (nstep_r == 3'd5) begin
          case (nsel_r)
            NS_P:    fst_nxt = c_zero_r ? F_RND : F_NRM;
            NS_C:    fst_nxt = F_SWAP;
            default: fst_nxt = F_RND;
          endcase
        end
      end
      F_SWAP:  fst_nxt = F_ALIGN;
      F_ALIGN: fst_nxt = F_ADD;
      F_ADD:   fst_nxt = (sum_c == 64'd0) ? F_IDLE : F_NRM;
      F_RND:   fst_nxt = F_PACK;
      F_PACK:  fst_nxt = F_IDLE;
      default: fst_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= F_IDLE;
    end else begin
      fst_r <= fst_nxt;
    end
  end

  // Flag the result for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= ((fst_r == F_IDLE) && req.start && spec_hit)
                || ((fst_r == F_ADD) && (sum_c == 64'd0))
                || (fst_r == F_PACK);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (fst_r)
      F_IDLE: begin
        if (req.start) begin
          res_r    <= spec_val;
          ma_r     <= sig_of(req.a);
          mb_r     <= sig_of(req.b);
          pe_r     <= exp_of(req.a) + exp_of(req.b);
          cm_r     <= sig_of(req.c);
          ce_r     <= exp_of(req.c);
          sp_r     <= sp_c;
          sc_r     <= req.c[31];
          c_zero_r <= is_zero(req.c);
        end
      end
      F_MUL: begin
        nv_r    <= {16'd0, 48'(ma_r) * 48'(mb_r)};
        ne_r    <= pe_r;
        nstep_r <= 3'd0;
        nsel_r  <= NS_P;
      end
      F_NRM: begin
        if ((nstep_r == 3'd5) && (nsel_r == NS_P)) begin
          sign_r <= sp_r;
        end
        if ((nstep_r == 3'd5) && (nsel_r == NS_P) && !c_zero_r) begin
          // hold the product, start on the addend
          pm_r    <= n_val >> 2;
          pme_r   <= n_exp + EXW'(2);
          nv_r    <= {40'd0, cm_r};
          ne_r    <= ce_r;
          nstep_r <= 3'd0;
          nsel_r  <= NS_C;
        end else begin
          nv_r    <= n_val;
          ne_r    <= n_exp;
          nstep_r <= nstep_r + 3'd1;
        end
      end
      F_SWAP: begin
        big_r   <= p_big ? pm_r : c_al;
        small_r <= p_big ? c_al : pm_r;
        ebig_r  <= p_big ? pme_r : c_ale;
        d_r     <= p_big ? EXW'(pme_r - c_ale) : EXW'(c_ale - pme_r);
        sign_r  <= p_big ? sp_r : sc_r;
        sub_r   <= (sp_r != sc_r);
      end
      F_ALIGN: small_r <= small_al;
      F_ADD: begin
        if (sum_c == 64'd0) begin
          // exact cancellation gives +0
          res_r <= 32'd0;
        end else begin
          nv_r    <= sum_c;
          ne_r    <= ebig_r;
          nstep_r <= 3'd0;
          nsel_r  <= NS_S;
        end
      end
      F_RND: begin
        rr_r <= 25'(wide[127:64]) + 25'(inc);
        q_r  <= q_c;
      end
      F_PACK: begin
        res_r <= pack_c;
      end
      default: ;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.bits = res_r;

  `CHK_NXT(a_done_pulse, clk, rst_n, rsp.done, !rsp.done)
  `CHK_IMP(a_start_idle, clk, rst_n, req.start, fst_r == F_IDLE)
  `CHK_IMP(a_nan_quiet, clk, rst_n, rsp.done && (&rsp.bits[30:23]) && (|rsp.bits[22:0]), rsp.bits[22])

endmodule

@@ rtl/fp32_gemm_blocked_mk8.sv @@
// ----------------------------------------------------------------------------
// fp32_gemm_blocked_mk8
// Blocked FP32 matrix multiply: A in eight-row blocks, B in eight-deep slices.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel (valid/ready): kind 0 writes one A word, kind 1 one B word,
//   kind 2 computes one C column for a block of eight rows; kind 3 is dropped.
//   A load writes its store and ready stays high. A compute item runs
//   8 * k_blocks depth steps for eight rows, one multiply-add at a time in a
//   single shared FP32 multiply-add unit.
//   Each multiply-add steps through read, start, multiply, three
//   6-step normalizations, align, add, round and pack; the first depth or a
//   zero or special operand takes fewer steps. Once all are done, a compute
//   item offers its eight results one per cycle while out_ready is high, in
//   row order, out_last on the eighth. in_ready is low from a compute item
//   until its last result is taken; a stalled out_ready holds the result.
//   cfg_* channel writes k_blocks (0 acts as 1, large values saturate); it is
//   always ready; the user must write it only while the block is idle, which
//   the block does not enforce. Reset (synchronous, rst_n low) sets k_blocks
//   to 1 and returns to idle; store contents are undefined until loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fp32_gemm_blocked_mk8 #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_DEPTH = 256,
  parameter int MAX_COLS  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [13:0] in_word_addr,
  input  logic [31:0] in_word_bits,
  input  logic [2:0]  in_row_block,
  input  logic [5:0]  in_col_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_row,
  output logic [5:0]  out_col,
  output logic [31:0] out_bits,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_k_blocks
);
  import fgemm_pkg::*;

  localparam int A_WORDS  = MAX_ROWS * MAX_DEPTH;
  localparam int B_WORDS  = MAX_DEPTH * MAX_COLS;
  localparam int A_AW     = $clog2(A_WORDS);
  localparam int B_AW     = $clog2(B_WORDS);
  localparam int KB_LIM   = (MAX_DEPTH / LANES < 63) ? MAX_DEPTH / LANES : 63;
  localparam int B_STRIDE = MAX_COLS * LANES;
  localparam int A_CW     = $clog2(LANES * KB_LIM * SLICE_WORDS);
  localparam int B_CW     = $clog2(KB_LIM * B_STRIDE + SLICE_WORDS * LANES);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_GO   = 5'b00100,
    S_WAIT = 5'b01000,
    S_OUT  = 5'b10000
  } st_t;

  st_t              st_r, st_nxt;
  logic [5:0]       k_blocks_r;
  logic [5:0]       kb_use_r, kb_cnt_r;
  logic [2:0]       k_cnt_r, r_cnt_r;
  logic [2:0]       rb_r;
  logic [5:0]       col_r;
  logic [A_CW-1:0]  a_off_r;
  logic [B_CW-1:0]  b_off_r;
  logic             a_oob_r, b_oob_r;
  logic [31:0]      sums_r [LANES];

  fma_req_t         fma_req;
  fma_rsp_t         fma_rsp;

  logic             in_acc, out_acc, last_fma;
  logic [5:0]       kb_use_c;
  logic [8:0]       rbk;
  logic [A_CW-1:0]  a_calc;
  logic [B_CW-1:0]  b_calc;
  logic             a_we, b_we;
  logic [31:0]      a_rdata, b_rdata;

  assign in_ready  = (st_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // Clamp the block count in use
  always_comb begin
    if (k_blocks_r == 6'd0) begin
      kb_use_c = 6'd1;
    end else if (32'(k_blocks_r) > 32'(KB_LIM)) begin
      kb_use_c = 6'(KB_LIM);
    end else begin
      kb_use_c = k_blocks_r;
    end
    rbk = 9'(in_row_block) * 9'(kb_use_c);
  end

  // Store addresses for the current depth and row
  assign a_calc   = a_off_r + A_CW'({k_cnt_r, r_cnt_r});
  assign b_calc   = b_off_r + B_CW'(k_cnt_r);
  assign last_fma = (r_cnt_r == 3'd7) && (k_cnt_r == 3'd7)
                    && (kb_cnt_r == kb_use_r - 6'd1);

  // Loads write straight into the stores
  assign a_we = in_acc && (in_kind == KIND_LOAD_A) && (32'(in_word_addr) < 32'(A_WORDS));
  assign b_we = in_acc && (in_kind == KIND_LOAD_B) && (32'(in_word_addr) < 32'(B_WORDS));

  fgemm_ram #(.WIDTH(32), .DEPTH(A_WORDS)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (A_AW'(in_word_addr)),
    .wdata (in_word_bits),
    .re    (st_r == S_RD),
    .raddr (A_AW'(a_calc)),
    .rdata (a_rdata)
  );

  fgemm_ram #(.WIDTH(32), .DEPTH(B_WORDS)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (B_AW'(in_word_addr)),
    .wdata (in_word_bits),
    .re    (st_r == S_RD),
    .raddr (B_AW'(b_calc)),
    .rdata (b_rdata)
  );

  // Operands for the shared multiply-add unit
  always_comb begin
    fma_req.start = (st_r == S_GO);
    fma_req.a     = a_oob_r ? 32'd0 : a_rdata;
    fma_req.b     = b_oob_r ? 32'd0 : b_rdata;
    fma_req.c     = ((kb_cnt_r == 6'd0) && (k_cnt_r == 3'd0)) ? SIGN_BIT : sums_r[r_cnt_r];
  end

  fgemm_fma u_fma (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fma_req),
    .rsp   (fma_rsp)
  );

  // Sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (in_acc && (in_kind == KIND_COMPUTE)) st_nxt = S_RD;
      S_RD:    st_nxt = S_GO;
      S_GO:    st_nxt = S_WAIT;
      S_WAIT:  if (fma_rsp.done) st_nxt = last_fma ? S_OUT : S_RD;
      S_OUT:   if (out_acc && (r_cnt_r == 3'd7)) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      k_blocks_r <= 6'd1;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        k_blocks_r <= cfg_k_blocks;
      end
    end
  end

  // Counters, address offsets and accumulators
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        if (in_acc && (in_kind == KIND_COMPUTE)) begin
          rb_r     <= in_row_block;
          col_r    <= in_col_index;
          kb_use_r <= kb_use_c;
          kb_cnt_r <= 6'd0;
          k_cnt_r  <= 3'd0;
          r_cnt_r  <= 3'd0;
          a_off_r  <= A_CW'(rbk) * A_CW'(SLICE_WORDS);
          b_off_r  <= B_CW'(in_col_index) * B_CW'(LANES);
        end
      end
      S_RD: begin
        a_oob_r <= (32'(a_calc) >= 32'(A_WORDS));
        b_oob_r <= (32'(b_calc) >= 32'(B_WORDS));
      end
      S_WAIT: begin
        if (fma_rsp.done) begin
          sums_r[r_cnt_r] <= fma_rsp.bits;
          r_cnt_r         <= r_cnt_r + 3'd1;
          if (r_cnt_r == 3'd7) begin
            k_cnt_r <= k_cnt_r + 3'd1;
            if (k_cnt_r == 3'd7) begin
              // advance to the next eight-deep slice
              kb_cnt_r <= kb_cnt_r + 6'd1;
              a_off_r  <= a_off_r + A_CW'(SLICE_WORDS);
              b_off_r  <= b_off_r + B_CW'(B_STRIDE);
            end
          end
        end
      end
      S_OUT: begin
        if (out_acc) begin
          r_cnt_r <= r_cnt_r + 3'd1;
        end
      end
      default: ;
    endcase
  end

  // Result channel
  assign out_valid = (st_r == S_OUT);
  assign out_row   = {rb_r, r_cnt_r};
  assign out_col   = col_r;
  assign out_bits  = sums_r[r_cnt_r];
  assign out_last  = (r_cnt_r == 3'd7);

  `CHK_IMP(a_port_excl, clk, rst_n, out_valid, !in_ready)
  `CHK_IMP(a_done_in_wait, clk, rst_n, fma_rsp.done, st_r == S_WAIT)
  `CHK_NXT(a_last_idle, clk, rst_n, out_valid && out_ready && out_last, in_ready)

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blocked FP32 matrix multiply testbench
// Loads A and B words, computes C columns under several k_blocks settings and
// checks every result item against an in-bench fused multiply-add predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import fgemm_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int STORE_WORDS = 16384;
  localparam int COL_COUNT   = 64;
  localparam int KB_LIMIT    = 32;

  typedef struct {
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] bits;
    logic        last;
  } c_elem_t;

  // Column predictor: mirrors the stores and the accumulators of the block
  class column_predictor;
    logic [31:0] a_mem [STORE_WORDS];
    logic [31:0] b_mem [STORE_WORDS];
    logic [31:0] row_acc [LANES];
    int          k_blocks;
    c_elem_t     pending_q [$];
    int          errors;

    function new();
      k_blocks = 1;
      errors = 0;
      foreach (row_acc[i]) row_acc[i] = '0;
      foreach (a_mem[i]) a_mem[i] = '0;
      foreach (b_mem[i]) b_mem[i] = '0;
    endfunction

    function bit is_nan(logic [31:0] x);
      return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    function bit is_inf(logic [31:0] x);
      return x[30:0] == INF_BITS[30:0];
    endfunction

    function bit is_zero(logic [31:0] x);
      return x[30:0] == 0;
    endfunction

    function int msb(longint unsigned v);
      for (int i = 63; i > 0; i--) if (v[i]) return i;
      return 0;
    endfunction

    function void unpack(input logic [31:0] x, output longint unsigned m, output int e);
      if (x[30:23] == 0) begin
        m = x[22:0];
        e = -149;
      end else begin
        m = {41'd1, x[22:0]};
        e = int'(x[30:23]) - 150;
      end
    endfunction

    // a * b + c, one rounding to nearest even
    function logic [31:0] fma32(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      logic [31:0] sp, sc, sgn;
      longint unsigned pm, cm, hi_m, lo_m, sum, r, lost, rem, half;
      int pe, ce, ehi, elo, d, q, sh, be;
      sp = (a ^ b) & SIGN_BIT;
      sc = c & SIGN_BIT;
      if (is_nan(a)) return a | QUIET_BIT;
      if (is_nan(b)) return b | QUIET_BIT;
      if (is_nan(c)) return c | QUIET_BIT;
      if (is_inf(a) || is_inf(b)) begin
        if (is_zero(a) || is_zero(b)) return DEFAULT_NAN;
        if (is_inf(c) && sc != sp) return DEFAULT_NAN;
        return sp | INF_BITS;
      end
      if (is_inf(c)) return c;
      if (is_zero(a) || is_zero(b)) begin
        if (is_zero(c)) return (sp == sc) ? sp : 32'd0;
        return c;
      end
      unpack(a, pm, pe);
      unpack(b, cm, ce);
      pm = pm * cm;
      pe = pe + ce;
      d = 61 - msb(pm);
      pm = pm << d;
      pe = pe - d;
      if (is_zero(c)) begin
        sum = pm;
        ehi = pe;
        sgn = sp;
      end else begin
        unpack(c, cm, ce);
        d = 61 - msb(cm);
        cm = cm << d;
        ce = ce - d;
        if (pe > ce || (pe == ce && pm >= cm)) begin
          hi_m = pm; ehi = pe; lo_m = cm; elo = ce; sgn = sp;
        end else begin
          hi_m = cm; ehi = ce; lo_m = pm; elo = pe; sgn = sc;
        end
        d = ehi - elo;
        if (d >= 63) begin
          lo_m = (lo_m != 0) ? 64'd1 : 64'd0;
        end else if (d > 0) begin
          lost = lo_m & ((64'd1 << d) - 1);
          lo_m = (lo_m >> d) | ((lost != 0) ? 64'd1 : 64'd0);
        end
        sum = (sp == sc) ? hi_m + lo_m : hi_m - lo_m;
        if (sum == 0) return 32'd0;
      end
      q = msb(sum) + ehi - 23;
      if (q < -149) q = -149;
      sh = q - ehi;
      if (sh <= 0) begin
        r = sum << (-sh);
      end else if (sh >= 64) begin
        r = (sh == 64 && sum > (64'd1 << 63)) ? 64'd1 : 64'd0;
      end else begin
        rem = sum & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        r = sum >> sh;
        if (rem > half || (rem == half && r[0])) r++;
      end
      if (r >= (64'd1 << 24)) begin
        r = r >> 1;
        q++;
      end
      if (r >= (64'd1 << 23)) begin
        be = q + 150;
        if (be >= 255) return sgn | INF_BITS;
        return sgn | (32'(be) << 23) | (32'(r) & 32'h007F_FFFF);
      end
      return sgn | 32'(r);
    endfunction

    function int used_blocks();
      if (k_blocks == 0) return 1;
      if (k_blocks > KB_LIMIT) return KB_LIMIT;
      return k_blocks;
    endfunction

    // Note one accepted input item; a compute queues its eight C elements
    function void note_item(logic [1:0] kind, logic [13:0] addr, logic [31:0] bits,
                            logic [2:0] rb, logic [5:0] col);
      int kbu, a_base, b_addr, a_addr;
      logic [31:0] acc;
      c_elem_t e;
      case (kind)
        KIND_LOAD_A: a_mem[addr] = bits;
        KIND_LOAD_B: b_mem[addr] = bits;
        KIND_COMPUTE: begin
          kbu = used_blocks();
          a_base = int'(rb) * kbu * SLICE_WORDS;
          for (int kb = 0; kb < kbu; kb++) begin
            for (int k = 0; k < LANES; k++) begin
              b_addr = kb * COL_COUNT * LANES + int'(col) * LANES + k;
              for (int r = 0; r < LANES; r++) begin
                a_addr = a_base + kb * SLICE_WORDS + k * LANES + r;
                acc = (kb == 0 && k == 0) ? SIGN_BIT : row_acc[r];
                row_acc[r] = fma32(a_mem[a_addr], b_mem[b_addr], acc);
              end
            end
          end
          for (int r = 0; r < LANES; r++) begin
            e.row = 6'(int'(rb) * LANES + r);
            e.col = col;
            e.bits = row_acc[r];
            e.last = (r == LANES - 1);
            pending_q.push_back(e);
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result item with the oldest expected element
    function void check_result(logic [5:0] row, logic [5:0] col, logic [31:0] bits,
                               logic last);
      c_elem_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result item: row %0d col %0d bits %h", row, col, bits);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (row !== e.row) begin
        $error("out_row: expected %0d, actual %0d", e.row, row);
        errors++;
      end
      if (col !== e.col) begin
        $error("out_col: expected %0d, actual %0d", e.col, col);
        errors++;
      end
      if (bits !== e.bits) begin
        $error("out_bits: expected %h, actual %h", e.bits, bits);
        errors++;
      end
      if (last !== e.last) begin
        $error("out_last: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [13:0] in_word_addr;
  logic [31:0] in_word_bits;
  logic [2:0]  in_row_block;
  logic [5:0]  in_col_index;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  out_row;
  logic [5:0]  out_col;
  logic [31:0] out_bits;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [5:0]  cfg_k_blocks;

  column_predictor col_pred;
  bit a_written [STORE_WORDS];
  bit b_written [STORE_WORDS];
  int idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both
  int hold_left;

  fp32_gemm_blocked_mk8 i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_word_addr (in_word_addr),
    .in_word_bits (in_word_bits),
    .in_row_block (in_row_block),
    .in_col_index (in_col_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_bits     (out_bits),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_k_blocks (cfg_k_blocks)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #200_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stalls per phase, long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (idle_mode == 2) begin
        out_ready = ($urandom_range(0, 99) >= 76);
      end else if (idle_mode == 3) begin
        out_ready = ($urandom_range(0, 99) >= 26);
      end else begin
        out_ready = 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        col_pred.check_result(out_row, out_col, out_bits, out_last);
    end
  end

  // Offer one item, with random sender gaps; returns after acceptance
  task automatic send_item(logic [1:0] kind, logic [13:0] addr, logic [31:0] bits,
                           logic [2:0] rb, logic [5:0] col);
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 76 : (idle_mode == 3) ? 26 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind = kind;
    in_word_addr = addr;
    in_word_bits = bits;
    in_row_block = rb;
    in_col_index = col;
    do @(posedge clk); while (!in_ready);
    col_pred.note_item(kind, addr, bits, rb, col);
    if (kind == KIND_LOAD_A) a_written[addr] = 1'b1;
    if (kind == KIND_LOAD_B) b_written[addr] = 1'b1;
    @(negedge clk);
  endtask

  task automatic drop_valid();
    in_valid = 1'b0;
  endtask

  // Hold the sender until every expected element has come, then let it settle
  task automatic drain();
    drop_valid();
    while (col_pred.pending_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_k_blocks(logic [5:0] value);
    cfg_valid = 1'b1;
    cfg_k_blocks = value;
    do @(posedge clk); while (!cfg_ready);
    col_pred.k_blocks = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    logic [31:0] specials [11] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
      32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001, 32'h0000_0001, 32'h807F_FFFF,
      32'h7F7F_FFFF, 32'h3F80_0000, 32'hBF80_0000};
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return specials[$urandom_range(0, 10)];
    if (pick < 12) return $urandom();
    return {1'($urandom_range(0, 1)), 8'($urandom_range(110, 140)), 23'($urandom())};
  endfunction

  // Noise: unused kind or a load at any address
  task automatic send_noise();
    logic [1:0] kind;
    kind = ($urandom_range(0, 2) == 0) ? KIND_UNUSED :
           ($urandom_range(0, 1) == 0) ? KIND_LOAD_A : KIND_LOAD_B;
    send_item(kind, 14'($urandom()), rand_word(), 3'($urandom()), 6'($urandom()));
  endtask

  // Fill unwritten B and A words of the column (refresh a few), then compute
  task automatic run_column(logic [2:0] rb, logic [5:0] col);
    int kbu, a_addr, b_addr;
    kbu = col_pred.used_blocks();
    for (int kb = 0; kb < kbu; kb++) begin
      for (int k = 0; k < LANES; k++) begin
        b_addr = kb * COL_COUNT * LANES + int'(col) * LANES + k;
        if (!b_written[b_addr] || $urandom_range(0, 31) == 0)
          send_item(KIND_LOAD_B, 14'(b_addr), rand_word(), 3'($urandom()),
                    6'($urandom()));
        if ($urandom_range(0, 19) == 0) send_noise();
        for (int r = 0; r < LANES; r++) begin
          a_addr = int'(rb) * kbu * SLICE_WORDS + kb * SLICE_WORDS + k * LANES + r;
          if (!a_written[a_addr] || $urandom_range(0, 31) == 0)
            send_item(KIND_LOAD_A, 14'(a_addr), rand_word(), 3'($urandom()),
                      6'($urandom()));
        end
      end
    end
    send_item(KIND_COMPUTE, 14'($urandom()), $urandom(), rb, col);
  endtask

  // Directed A contents of block 0: one special case per row, a plain value in row 7
  function automatic logic [31:0] directed_a(int d, int r);
    case (r)
      0: return (d == 0) ? 32'h7F80_0001 : 32'h3F80_0000;  // signaling NaN
      1: return (d == 0) ? 32'h7F80_0000 :                  // opposite infinities
                (d == 1) ? 32'hFF80_0000 : 32'h3F80_0000;
      2: return (d == 0) ? 32'h3F80_0000 :                  // exact cancellation
                (d == 1) ? 32'hBF80_0000 : 32'h0000_0000;
      3: return 32'h0000_0001;                              // subnormals
      4: return 32'h7F7F_FFFF;                              // overflow
      5: return 32'h0000_0000;                              // zero, inf times zero
      6: return 32'h8000_0000;
      default: return 32'h3FC0_0000;
    endcase
  endfunction

  initial begin
    int kb_plan [4] = '{1, 0, 2, 1};
    int n_cols;
    col_pred = new();
    idle_mode = 0;
    hold_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_LOAD_A;
    in_word_addr = '0;
    in_word_bits = '0;
    in_row_block = '0;
    in_col_index = '0;
    cfg_valid = 1'b0;
    cfg_k_blocks = 6'd1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int p = 0; p < 4; p++) begin
      write_k_blocks(6'(kb_plan[p]));
      idle_mode = p % 4;
      if (p == 0) begin
        // Directed: column 0 with B all one, column 1 with infinity at depth 0
        for (int d = 0; d < LANES; d++) begin
          send_item(KIND_LOAD_B, 14'(d), 32'h3F80_0000, 3'd0, 6'd0);
          send_item(KIND_LOAD_B, 14'(LANES + d),
                    (d == 0) ? 32'h7F80_0000 : (d == 1) ? 32'h4000_0000 : 32'h3F80_0000,
                    3'd0, 6'd0);
          for (int r = 0; r < LANES; r++)
            send_item(KIND_LOAD_A, 14'(d * LANES + r), directed_a(d, r), 3'd0, 6'd0);
        end
        send_item(KIND_COMPUTE, '0, '0, 3'd0, 6'd0);
        send_item(KIND_COMPUTE, '1, '1, 3'd0, 6'd1);
        send_item(KIND_UNUSED, '1, '1, 3'd7, 6'd63);
      end
      // Hold the receiver past the first column so the next one stalls the input
      if (p == 3) hold_left = 2500;
      n_cols = (p == 1 || p == 3) ? 2 : 1;
      for (int c = 0; c < n_cols; c++) begin
        run_column((kb_plan[p] == 2) ? 3'd0 : 3'($urandom_range(0, 1)),
                   6'($urandom()));
        if (p == 1 && c == 0) drain();
      end
      drain();
    end

    if (col_pred.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/fgemm_pkg.sv
rtl/fgemm_ram.sv
rtl/fgemm_fma.sv
rtl/fp32_gemm_blocked_mk8.sv
tb/tb_top.sv
